// ===== hdl/cbmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmp_pkg
// Shared types and constants for the cluster beacon message parser.
// ----------------------------------------------------------------------------
package cbmp_pkg;

  localparam int unsigned FIXED_OCTETS       = 4;
  localparam int unsigned SCALING_NARROW_MAX = 4;
  localparam int unsigned POS_W              = 4;
  localparam int unsigned SCALING_W          = 4;

  typedef struct packed {
    logic [7:0]  frame_number;
    logic [4:0]  flag_bits;
    logic [3:0]  max_tx_power_code;
    logic [15:0] beacon_offset;
    logic [12:0] cluster_channel;
    logic [31:0] next_beacon_time;
    logic [3:0]  network_period_code;
    logic [3:0]  cluster_period_code;
    logic [3:0]  trigger_count_code;
    logic [1:0]  relative_quality_code;
    logic [1:0]  minimum_quality_code;
    logic [3:0]  message_length;
  } cbmp_result_t;

endpackage

// ===== hdl/cluster_beacon_message_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_beacon_message_parser_top
// Result beat is registered; it is valid in the cycle after the last message byte is taken.
// Throughput: one byte per cycle; input stalls only while a result waits
// under output stall.
// Reset (rst, synchronous): parser idle, scaling 0, output empty.
// Cluster beacon message parser: byte stream in, decoded field set out.
// ----------------------------------------------------------------------------
module cluster_beacon_message_parser_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbmp_pkg::SCALING_W-1:0]   subcarrier_scaling,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             start_of_message,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       frame_number,
  output logic [4:0]                       flag_bits,
  output logic [3:0]                       max_tx_power_code,
  output logic [15:0]                      beacon_offset,
  output logic [12:0]                      cluster_channel,
  output logic [31:0]                      next_beacon_time,
  output logic [3:0]                       network_period_code,
  output logic [3:0]                       cluster_period_code,
  output logic [3:0]                       trigger_count_code,
  output logic [1:0]                       relative_quality_code,
  output logic [1:0]                       minimum_quality_code,
  output logic [3:0]                       message_length
);
  import cbmp_pkg::*;

  logic [SCALING_W-1:0] scaling;
  logic                 beat;
  logic                 done;
  cbmp_result_t         result_new;
  cbmp_result_t         result_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign beat      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaling <= '0;
    end else if (cfg_valid && cfg_ready) begin
      scaling <= subcarrier_scaling;
    end
  end

  cbmp_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .beat             (beat),
    .data_byte        (data_byte),
    .start_of_message (start_of_message),
    .scaling          (scaling),
    .done             (done),
    .result           (result_new)
  );

  cbmp_result_reg u_result_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (done),
    .result_in  (result_new),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (result_q)
  );

  assign frame_number          = result_q.frame_number;
  assign flag_bits             = result_q.flag_bits;
  assign max_tx_power_code     = result_q.max_tx_power_code;
  assign beacon_offset         = result_q.beacon_offset;
  assign cluster_channel       = result_q.cluster_channel;
  assign next_beacon_time      = result_q.next_beacon_time;
  assign network_period_code   = result_q.network_period_code;
  assign cluster_period_code   = result_q.cluster_period_code;
  assign trigger_count_code    = result_q.trigger_count_code;
  assign relative_quality_code = result_q.relative_quality_code;
  assign minimum_quality_code  = result_q.minimum_quality_code;
  assign message_length        = result_q.message_length;

endmodule

// ===== hdl/cbmp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmp_parser
// Byte position tracking and field capture; flags a finished message.
// ----------------------------------------------------------------------------
module cbmp_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                beat,
  input  logic [7:0]                          data_byte,
  input  logic                                start_of_message,
  input  logic [cbmp_pkg::SCALING_W-1:0]      scaling,
  output logic                                done,
  output cbmp_pkg::cbmp_result_t              result
);
  import cbmp_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             in_message, in_message_next;
  logic [3:0]       expected_length, expected_length_next;
  logic             fo_wide, fo_wide_next;
  logic [7:0]       frame_number_reg, frame_number_next;
  logic [4:0]       flag_reg, flag_next;
  logic [7:0]       period_octet, period_next;
  logic [7:0]       quality_octet, quality_next;
  logic [3:0]       power_code_reg, power_next;
  logic [15:0]      offset_reg, offset_next;
  logic [12:0]      channel_reg, channel_next;
  logic [31:0]      time_reg, time_next;

  logic             active;
  logic [POS_W-1:0] pos;
  logic [4:0]       pos_ext, pos_inc;
  logic [4:0]       off_fo, off_nc, off_tn, fo_size;
  logic             tx, fo, nc, tn;

  always_comb begin
    active = beat && (start_of_message || in_message);
    pos    = start_of_message ? '0 : byte_position;

    // start: drop any partial message and clear fields
    expected_length_next = start_of_message ? 4'(FIXED_OCTETS) : expected_length;
    fo_wide_next         = start_of_message ? 1'b0 : fo_wide;
    frame_number_next    = start_of_message ? '0 : frame_number_reg;
    flag_next            = start_of_message ? '0 : flag_reg;
    period_next          = start_of_message ? '0 : period_octet;
    quality_next         = start_of_message ? '0 : quality_octet;
    power_next           = start_of_message ? '0 : power_code_reg;
    offset_next          = start_of_message ? '0 : offset_reg;
    channel_next         = start_of_message ? '0 : channel_reg;
    time_next            = start_of_message ? '0 : time_reg;

    tx      = flag_next[4];
    fo      = flag_next[2];
    nc      = flag_next[1];
    tn      = flag_next[0];
    fo_size = fo_wide_next ? 5'd2 : 5'd1;
    off_fo  = 5'(FIXED_OCTETS) + {4'd0, tx};
    off_nc  = off_fo + (fo ? fo_size : 5'd0);
    off_tn  = off_nc + (nc ? 5'd2 : 5'd0);
    pos_ext = {1'b0, pos};
    pos_inc = pos_ext + 5'd1;

    case (pos)
      4'd0: frame_number_next = data_byte;
      4'd1: begin
        flag_next    = data_byte[4:0];
        fo_wide_next = (scaling > SCALING_W'(SCALING_NARROW_MAX));
        expected_length_next = 4'(FIXED_OCTETS) + {3'd0, data_byte[4]}
          + (data_byte[2] ? (fo_wide_next ? 4'd2 : 4'd1) : 4'd0)
          + (data_byte[1] ? 4'd2 : 4'd0)
          + (data_byte[0] ? 4'd4 : 4'd0);
      end
      4'd2: period_next  = data_byte;
      4'd3: quality_next = data_byte;
      default: begin
        if (tx && pos_ext == 5'(FIXED_OCTETS)) begin
          power_next = data_byte[3:0];
        end else if (fo && pos_ext >= off_fo && pos_ext < off_fo + fo_size) begin
          offset_next = {offset_next[7:0], data_byte};
        end else if (nc && pos_ext == off_nc) begin
          channel_next = {data_byte[4:0], 8'd0};
        end else if (nc && pos_ext == off_nc + 5'd1) begin
          channel_next = {channel_next[12:8], data_byte};
        end else if (tn && pos_ext >= off_tn && pos_ext < off_tn + 5'd4) begin
          time_next = {time_next[23:0], data_byte};
        end
      end
    endcase

    done = active && (pos_inc >= 5'(FIXED_OCTETS))
           && (pos_inc >= {1'b0, expected_length_next});

    byte_position_next = pos_inc[POS_W-1:0];
    in_message_next    = !done;

    result.frame_number          = frame_number_next;
    result.flag_bits             = flag_next;
    result.max_tx_power_code     = power_next;
    result.beacon_offset         = offset_next;
    result.cluster_channel       = channel_next;
    result.next_beacon_time      = time_next;
    result.network_period_code   = period_next[7:4];
    result.cluster_period_code   = period_next[3:0];
    result.trigger_count_code    = quality_next[7:4];
    result.relative_quality_code = quality_next[3:2];
    result.minimum_quality_code  = quality_next[1:0];
    result.message_length        = expected_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      in_message      <= 1'b0;
      expected_length <= 4'(FIXED_OCTETS);
    end else if (active) begin
      byte_position   <= byte_position_next;
      in_message      <= in_message_next;
      expected_length <= expected_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      fo_wide          <= fo_wide_next;
      frame_number_reg <= frame_number_next;
      flag_reg         <= flag_next;
      period_octet     <= period_next;
      quality_octet    <= quality_next;
      power_code_reg   <= power_next;
      offset_reg       <= offset_next;
      channel_reg      <= channel_next;
      time_reg         <= time_next;
    end
  end

endmodule

// ===== hdl/cbmp_result_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmp_result_reg
// Output register holding one finished result beat until it is taken.
// ----------------------------------------------------------------------------
module cbmp_result_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  cbmp_pkg::cbmp_result_t result_in,
  input  logic                   out_stall,
  output logic                   out_valid,
  output cbmp_pkg::cbmp_result_t result_out
);
  import cbmp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule
